FILE: rtl/tpq_pkg.sv
// Package for the ticket priority queue: entry layout, command and status codes,
// and the control word broadcast to every cell of the sorted chain.
// Depends on nothing; imported by tpq_cell, ticket_priority_queue, tpq_checker and the testbench.
package tpq_pkg;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_CHANGE = 2'd1,
        CMD_POP    = 2'd2,
        CMD_LOOKUP = 2'd3
    } cmd_t;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic [1:0] PRIO_LOW  = 2'd0;
    localparam logic [1:0] PRIO_HIGH = 2'd2;

    typedef struct packed {
        logic [15:0] id;
        logic [1:0]  prio;
        logic [31:0] arr_time;
    } entry_t;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2,
        OP_POP    = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        entry_t   ent;
    } chain_ctl_t;

endpackage

FILE: rtl/tpq_cell.sv
// One slot of the sorted chain: holds an entry and a valid flag, and moves
// entries to or from its neighbors on insert, pop and removal.
// Depends on tpq_pkg.
module tpq_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  tpq_pkg::chain_ctl_t ctl,
    input  tpq_pkg::entry_t    prev_ent,
    input  logic               prev_valid,
    input  logic               prev_keep,
    input  tpq_pkg::entry_t    next_ent,
    input  logic               next_valid,
    input  logic               hit_in,
    output tpq_pkg::entry_t    ent,
    output logic               valid,
    output logic               keep,
    output logic               hit_out,
    output logic               first
);
    import tpq_pkg::*;

    entry_t ent_reg;
    entry_t ent_next;
    logic   valid_reg;
    logic   valid_next;
    logic   match;

    // Entry stays ahead of the new one: higher priority, or equal priority and
    // same or earlier time.
    assign keep = valid_reg &&
                  ((ent_reg.prio > ctl.ent.prio) ||
                   ((ent_reg.prio == ctl.ent.prio) &&
                    (ent_reg.arr_time <= ctl.ent.arr_time)));

    assign match   = valid_reg && (ent_reg.id == ctl.ent.id);
    assign hit_out = hit_in | match;
    assign first   = match & ~hit_in;

    always_comb
    begin
        ent_next   = ent_reg;
        valid_next = valid_reg;
        case (ctl.op)
            OP_INSERT:
            begin
                if (!keep)
                begin
                    if (prev_keep)
                    begin
                        ent_next   = ctl.ent;
                        valid_next = 1'b1;
                    end
                    else
                    begin
                        ent_next   = prev_ent;
                        valid_next = prev_valid;
                    end
                end
            end
            OP_REMOVE:
            begin
                if (hit_out)
                begin
                    ent_next   = next_ent;
                    valid_next = next_valid;
                end
            end
            OP_POP:
            begin
                ent_next   = next_ent;
                valid_next = next_valid;
            end
            default:
            begin
                ent_next   = ent_reg;
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

    assign ent   = ent_reg;
    assign valid = valid_reg;

endmodule

FILE: rtl/ticket_priority_queue.sv
// Top level of the ticket priority queue: command register, sequencer and a
// chain of QUEUE_DEPTH sorted cells. Depends on tpq_pkg and tpq_cell.
//
//   channel   | handshake           | payload
//   ----------+---------------------+-------------------------------------------
//   command   | start in, busy out  | cmd, ticket_id, new_priority, arrival_time
//   result    | done out (strobe)   | status, out_id, out_priority, out_time,
//             |                     | occupancy
//
// A command transfers on a clock edge with start high and busy low. Insert, pop
// and lookup go through capture, then one chain update in S_EXEC; a change
// priority that finds its id removes the entry in S_EXEC and reinserts it in
// S_REINS, and one that misses ends in S_EXEC like the others.
// Only one broadcast chain update is applied per cycle, hence the two steps.
// The result is shown for one cycle with done high; busy is already low then,
// so the next command may transfer in that same cycle. The receiver cannot stall.
// Reset empties the queue at once (valid flags only); no clearing pass.
module ticket_priority_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  cmd,
    input  logic [15:0] ticket_id,
    input  logic [1:0]  new_priority,
    input  logic [31:0] arrival_time,
    output logic        done,
    output logic [1:0]  status,
    output logic [15:0] out_id,
    output logic [1:0]  out_priority,
    output logic [31:0] out_time,
    output logic [4:0]  occupancy
);
    import tpq_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_EXEC  = 3'b010,
        S_REINS = 3'b100
    } state_t;

    state_t      state_reg;
    state_t      state_next;
    cmd_t        cmd_reg;
    logic [15:0] id_reg;
    logic [1:0]  prio_reg;
    logic [31:0] time_reg;
    logic [31:0] time_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    logic        done_reg;
    logic        done_next;
    logic [1:0]  status_reg;
    logic [1:0]  status_next;
    entry_t      out_reg;
    entry_t      out_next;

    chain_ctl_t  ctl;
    entry_t      cell_ent   [QUEUE_DEPTH];
    logic        cell_valid [QUEUE_DEPTH];
    logic        cell_keep  [QUEUE_DEPTH];
    logic        cell_first [QUEUE_DEPTH];
    logic        hit        [QUEUE_DEPTH+1];
    entry_t      found_ent;
    logic        found;
    logic        full;
    logic        accept;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start & ~busy;
    assign found  = hit[QUEUE_DEPTH];
    assign full   = cell_valid[QUEUE_DEPTH-1];
    assign hit[0] = 1'b0;

    // ---------------------------------------------------------------------
    // Chain of cells: each cell sees its left and right neighbor only
    // ---------------------------------------------------------------------
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        entry_t p_ent;
        logic   p_valid;
        logic   p_keep;
        entry_t n_ent;
        logic   n_valid;

        if (i == 0)
        begin : g_head
            // The head behaves as if an entry ahead of it always stays put.
            assign p_ent   = '0;
            assign p_valid = 1'b0;
            assign p_keep  = 1'b1;
        end
        else
        begin : g_body
            assign p_ent   = cell_ent[i-1];
            assign p_valid = cell_valid[i-1];
            assign p_keep  = cell_keep[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_tail
            assign n_ent   = '0;
            assign n_valid = 1'b0;
        end
        else
        begin : g_mid
            assign n_ent   = cell_ent[i+1];
            assign n_valid = cell_valid[i+1];
        end

        tpq_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .prev_ent   (p_ent),
            .prev_valid (p_valid),
            .prev_keep  (p_keep),
            .next_ent   (n_ent),
            .next_valid (n_valid),
            .hit_in     (hit[i]),
            .ent        (cell_ent[i]),
            .valid      (cell_valid[i]),
            .keep       (cell_keep[i]),
            .hit_out    (hit[i+1]),
            .first      (cell_first[i])
        );
    end

    // Select the first matching entry; at most one first flag is set.
    always_comb
    begin
        found_ent = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (cell_first[i])
            begin
                found_ent = found_ent | cell_ent[i];
            end
        end
    end

    // ---------------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------------
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        time_next   = time_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        out_next    = out_reg;
        ctl.op      = OP_HOLD;
        ctl.ent.id  = id_reg;
        ctl.ent.prio = (state_reg == S_REINS) ? prio_reg : PRIO_LOW;
        ctl.ent.arr_time = time_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                    time_next  = arrival_time;
                end
            end
            S_EXEC:
            begin
                state_next  = S_IDLE;
                done_next   = 1'b1;
                status_next = ST_DONE;
                out_next    = '0;
                case (cmd_reg)
                    CMD_INSERT:
                    begin
                        if (full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            ctl.op     = OP_INSERT;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    CMD_POP:
                    begin
                        if (!cell_valid[0])
                        begin
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            ctl.op     = OP_POP;
                            out_next   = cell_ent[0];
                            count_next = count_reg - CW'(1);
                        end
                    end
                    CMD_LOOKUP:
                    begin
                        if (!found)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            out_next = found_ent;
                        end
                    end
                    CMD_CHANGE:
                    begin
                        if (!found)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            // Drop the entry now; reinsert it with its own time next.
                            ctl.op     = OP_REMOVE;
                            time_next  = found_ent.arr_time;
                            done_next  = 1'b0;
                            state_next = S_REINS;
                        end
                    end
                    default:
                    begin
                        status_next = ST_EMPTY;
                    end
                endcase
            end
            S_REINS:
            begin
                ctl.op      = OP_INSERT;
                state_next  = S_IDLE;
                done_next   = 1'b1;
                status_next = ST_DONE;
                out_next    = '0;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // Command capture and result payload; no reset needed.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= cmd_t'(cmd);
            id_reg   <= ticket_id;
            prio_reg <= (new_priority > PRIO_HIGH) ? PRIO_HIGH : new_priority;
        end
        time_reg   <= time_next;
        status_reg <= status_next;
        out_reg    <= out_next;
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign out_id       = out_reg.id;
    assign out_priority = out_reg.prio;
    assign out_time     = out_reg.arr_time;
    assign occupancy    = 5'(count_reg);

endmodule

FILE: sim/tpq_checker.sv
// Checker for the ticket priority queue: watches the command and result
// channels, predicts every result and compares it field by field.
// Depends on tpq_pkg for the entry layout and the command and status codes.
`timescale 1ns / 1ps

module tpq_checker #(
    parameter int DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  cmd,
    input  logic [15:0] ticket_id,
    input  logic [1:0]  new_priority,
    input  logic [31:0] arrival_time,
    input  logic        done,
    input  logic [1:0]  status,
    input  logic [15:0] out_id,
    input  logic [1:0]  out_priority,
    input  logic [31:0] out_time,
    input  logic [4:0]  occupancy,
    output int          outstanding,
    output int          errors
);
    import tpq_pkg::*;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] id;
        logic [1:0]  prio;
        logic [31:0] arr_time;
        logic [4:0]  occupancy;
    } outcome_t;

    // Shadow of the queue, head first, and the results still owed by the block.
    entry_t   tickets[$];
    outcome_t owed_results[$];

    function automatic int find_first(logic [15:0] id);
        for (int i = 0; i < tickets.size(); i++)
        begin
            if (tickets[i].id == id)
                return i;
        end
        return -1;
    endfunction

    // Go behind every entry of higher priority, or of equal priority and no later time.
    function automatic void place_sorted(entry_t e);
        int pos;
        pos = 0;
        while (pos < tickets.size() &&
               (tickets[pos].prio > e.prio ||
                (tickets[pos].prio == e.prio && tickets[pos].arr_time <= e.arr_time)))
            pos++;
        tickets.insert(pos, e);
    endfunction

    function automatic outcome_t apply_command(cmd_t c, logic [15:0] id, logic [1:0] np,
                                               logic [31:0] t);
        outcome_t   r;
        entry_t     e;
        int         pos;
        logic [1:0] prio;
        r = '0;
        r.status = ST_DONE;
        prio = (np > PRIO_HIGH) ? PRIO_HIGH : np;
        case (c)
            CMD_INSERT:
            begin
                if (tickets.size() >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    e.id = id;
                    e.prio = PRIO_LOW;
                    e.arr_time = t;
                    place_sorted(e);
                end
            end
            CMD_CHANGE:
            begin
                pos = find_first(id);
                if (pos < 0)
                    r.status = ST_EMPTY;
                else
                begin
                    e = tickets[pos];
                    tickets.delete(pos);
                    e.prio = prio;
                    place_sorted(e);
                end
            end
            CMD_POP:
            begin
                if (tickets.size() == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    e = tickets.pop_front();
                    r.id = e.id;
                    r.prio = e.prio;
                    r.arr_time = e.arr_time;
                end
            end
            default:
            begin
                pos = find_first(id);
                if (pos < 0)
                    r.status = ST_EMPTY;
                else
                begin
                    r.id = tickets[pos].id;
                    r.prio = tickets[pos].prio;
                    r.arr_time = tickets[pos].arr_time;
                end
            end
        endcase
        r.occupancy = 5'(tickets.size());
        return r;
    endfunction

    function automatic void compare_result(outcome_t want);
        if (status !== want.status)
        begin
            $error("status: expected %0d, got %0d", want.status, status);
            errors++;
        end
        if (out_id !== want.id)
        begin
            $error("out_id: expected %0h, got %0h", want.id, out_id);
            errors++;
        end
        if (out_priority !== want.prio)
        begin
            $error("out_priority: expected %0d, got %0d", want.prio, out_priority);
            errors++;
        end
        if (out_time !== want.arr_time)
        begin
            $error("out_time: expected %0h, got %0h", want.arr_time, out_time);
            errors++;
        end
        if (occupancy !== want.occupancy)
        begin
            $error("occupancy: expected %0d, got %0d", want.occupancy, occupancy);
            errors++;
        end
    endfunction

    // Retire the result first, then book the command that transfers on this edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tickets.delete();
            owed_results.delete();
            outstanding <= 0;
            errors = 0;
        end
        else
        begin
            if (done === 1'b1)
            begin
                if (owed_results.size() == 0)
                begin
                    $error("result strobe with no command outstanding");
                    errors++;
                end
                else
                    compare_result(owed_results.pop_front());
            end
            if (start && !busy)
                owed_results.push_back(apply_command(cmd_t'(cmd), ticket_id, new_priority,
                                                     arrival_time));
            outstanding <= owed_results.size();
        end
    end

endmodule

FILE: sim/ticket_priority_queue_tb.sv
// Testbench top for the ticket priority queue: clock, reset, command stimulus
// and the verdict. Depends on tpq_pkg, the block itself and tpq_checker.
`timescale 1ns / 1ps

module ticket_priority_queue_tb;
    import tpq_pkg::*;

    localparam int DEPTH         = 16;
    localparam int ITEMS_PER_PHASE = 500;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [1:0]  cmd = CMD_INSERT;
    logic [15:0] ticket_id = '0;
    logic [1:0]  new_priority = '0;
    logic [31:0] arrival_time = '0;
    logic        busy;
    logic        done;
    logic [1:0]  status;
    logic [15:0] out_id;
    logic [1:0]  out_priority;
    logic [31:0] out_time;
    logic [4:0]  occupancy;
    int          outstanding;
    int          errors;

    // A few recurring ids make duplicates, lookup hits and change hits common.
    logic [15:0] id_pool[6] = '{16'h0000, 16'hFFFF, 16'h0001, 16'hA5A5, 16'h5A5A, 16'h8000};
    // Chance in percent of an idle gap after each command, per phase: none, heavy, none, light.
    int          idle_pct[4] = '{0, 59, 0, 12};
    int          insert_weight;

    always #2 clk = ~clk;

    ticket_priority_queue #(
        .QUEUE_DEPTH(DEPTH)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .ticket_id    (ticket_id),
        .new_priority (new_priority),
        .arrival_time (arrival_time),
        .done         (done),
        .status       (status),
        .out_id       (out_id),
        .out_priority (out_priority),
        .out_time     (out_time),
        .occupancy    (occupancy)
    );

    tpq_checker #(
        .DEPTH(DEPTH)
    ) queue_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .ticket_id    (ticket_id),
        .new_priority (new_priority),
        .arrival_time (arrival_time),
        .done         (done),
        .status       (status),
        .out_id       (out_id),
        .out_priority (out_priority),
        .out_time     (out_time),
        .occupancy    (occupancy),
        .outstanding  (outstanding),
        .errors       (errors)
    );

    // Present one command and hold it until it transfers. Called at a rising
    // edge; returns at the edge where start was high and busy low. Start stays
    // high on return, so back-to-back commands never drop it in between.
    task automatic issue(input cmd_t c, input logic [15:0] id, input logic [1:0] np,
                         input logic [31:0] t);
        start <= 1'b1;
        cmd <= c;
        ticket_id <= id;
        new_priority <= np;
        arrival_time <= t;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // With a chance of pct percent, idle the sender for a random gap, scrambling the payload so the block
    // must ignore whatever sits on the ports while start is low.
    task automatic pause_sender(input int pct);
        if ($urandom_range(99) < pct)
        begin
            start <= 1'b0;
            cmd <= 2'($urandom_range(3));
            ticket_id <= 16'($urandom);
            new_priority <= 2'($urandom_range(3));
            arrival_time <= $urandom;
            repeat ($urandom_range(1, 5))
                @(posedge clk);
        end
    endtask

    // Drop start and hold off until every predicted result has come back.
    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    function automatic logic [15:0] pick_id();
        if ($urandom_range(3) == 0)
            return 16'($urandom);
        return id_pool[$urandom_range(5)];
    endfunction

    // Mostly tiny times so equal keys and ties come up often; extremes too.
    function automatic logic [31:0] pick_time();
        case ($urandom_range(9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2, 3:    return $urandom;
            default: return $urandom_range(15);
        endcase
    endfunction

    function automatic cmd_t pick_cmd(input int weight);
        if ($urandom_range(99) < weight)
            return CMD_INSERT;
        case ($urandom_range(2))
            0:       return CMD_CHANGE;
            1:       return CMD_POP;
            default: return CMD_LOOKUP;
        endcase
    endfunction

    initial
    begin
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty-queue misses, extremes, duplicates and equal keys,
        // saturating priority, change that lands behind an equal key.
        issue(CMD_POP,    16'h0000, 2'd0, 32'h0);
        issue(CMD_LOOKUP, 16'hFFFF, 2'd0, 32'h0);
        issue(CMD_CHANGE, 16'h0000, 2'd2, 32'h0);
        issue(CMD_INSERT, 16'h0000, 2'd0, 32'h0000_0000);
        issue(CMD_INSERT, 16'hFFFF, 2'd3, 32'hFFFF_FFFF);
        issue(CMD_INSERT, 16'h0000, 2'd0, 32'h0000_0005);
        issue(CMD_INSERT, 16'h1234, 2'd0, 32'h0000_0005);
        issue(CMD_LOOKUP, 16'h0000, 2'd0, 32'h0);
        issue(CMD_LOOKUP, 16'h9999, 2'd0, 32'h0);
        issue(CMD_CHANGE, 16'h0000, 2'd3, 32'h0);
        issue(CMD_CHANGE, 16'hFFFF, 2'd1, 32'h0);
        issue(CMD_CHANGE, 16'h1234, 2'd0, 32'h0);
        issue(CMD_CHANGE, 16'h4321, 2'd1, 32'h0);
        issue(CMD_POP,    16'h0000, 2'd0, 32'h0);
        // Fill to the brim, then one more insert to see the full status.
        for (int i = 0; i < DEPTH - 2; i++)
            issue(CMD_INSERT, 16'(i), 2'd0, 32'(i % 3));
        issue(CMD_LOOKUP, 16'h000C, 2'd0, 32'h0);

        // Random phases, each opening with a full drain of the results.
        for (int phase = 0; phase < 4; phase++)
        begin
            drain_results();
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // Swing the insert mix so the queue both fills and empties.
                if (n % 50 == 0)
                    insert_weight = ($urandom_range(2) == 0) ? 15 :
                                    ($urandom_range(1) == 0) ? 45 : 75;
                issue(pick_cmd(insert_weight), pick_id(), 2'($urandom_range(3)),
                      pick_time());
                pause_sender(idle_pct[phase]);
            end
        end

        drain_results();
        repeat (8)
            @(posedge clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: files.f
rtl/tpq_pkg.sv
rtl/tpq_cell.sv
rtl/ticket_priority_queue.sv
sim/tpq_checker.sv
sim/ticket_priority_queue_tb.sv
